// ----- rtl/white_brown_pink_noise_generator_core_macros.svh -----
// Assertion macros for the noise generator core.
`ifndef WHITE_BROWN_PINK_NOISE_GENERATOR_CORE_MACROS_SVH
`define WHITE_BROWN_PINK_NOISE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WBPN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbpn assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WBPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbpn assertion failed");

`endif

// ----- rtl/wbpn_pkg.sv -----
// Package: constants, widths and types of the noise generator core.
package wbpn_pkg;

   localparam int OCTAVES_DEF = 16;

   localparam logic [31:0] LCG_MUL = 32'd196314165;
   localparam logic [31:0] LCG_ADD = 32'd907633515;

   localparam int DRAW_W   = 23;
   localparam int WALK_W   = 27;
   localparam int SUM_W    = 26;
   localparam int STORE_W  = 24;
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = DRAW_W + GAIN_W;
   localparam int SAMPLE_W = 35;

   localparam logic signed [WALK_W:0] BROWN_LIMIT = 28'sd33554432;
   localparam logic signed [SUM_W:0]  PINK_LIMIT  = 27'sd16777216;

   typedef enum logic [1:0] {
      ACT_WHITE = 2'd0,
      ACT_BROWN = 2'd1,
      ACT_PINK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAW,
      S_EVAL,
      S_SCALE,
      S_TAIL,
      S_LAST,
      S_POST
   } state_type;

endpackage

// ----- rtl/white_brown_pink_noise_generator_core.sv -----
// Noise generator core: white, brown and pink samples from one shared LCG step unit.
// Steps: white DRAW, EVAL, SCALE, POST; unused action POST; brown DRAW, EVAL per draw, POST;
// pink READ, DRAW, EVAL per draw, TAIL, LAST, POST. One transaction in flight; req_tready
// only in idle. The LCG multiplier is the shared unit; band rejections re-run DRAW and EVAL.
// Reset (synchronous, active high): seed 1, generator 1, walk and sum 0, counter 1,
// octave entries read as zero until rewritten (per-entry valid bits), output empty.
`include "white_brown_pink_noise_generator_core_macros.svh"

module white_brown_pink_noise_generator_core
   import wbpn_pkg::*;
#(
   parameter int OCTAVES = OCTAVES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] white_gain (signed Q8.8)
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [34:0] sample (signed), [39:35] zero
   // seed register
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int KW = $clog2(OCTAVES);

   // sequencer and transaction context
   state_type                  state_ff, state_in;
   action_type                 action_ff, action_in;
   logic signed [GAIN_W-1:0]   gain_ff, gain_in;

   // noise state
   logic [31:0]                gen_ff, gen_in;
   logic signed [WALK_W-1:0]   walk_ff, walk_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [31:0]                count_ff, count_in;

   // octave store: per-entry valid bits stand in for the zero reset
   logic signed [STORE_W-1:0]  store [OCTAVES];
   logic [OCTAVES-1:0]         valid_ff;
   logic                       store_we;
   logic [KW-1:0]              k_ff, k_in, k_calc;
   logic signed [STORE_W-1:0]  prev_ff;

   // datapath registers
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // shared step unit and derived values
   logic [31:0]                gen_next;
   logic signed [DRAW_W-1:0]   w;
   logic signed [WALK_W:0]     brown_next;
   logic signed [SUM_W:0]      pink_next;
   logic signed [SUM_W:0]      tail_sum;
   logic [31:0]                lsb;
   logic                       rsp_free;
   logic                       walk_ok;
   logic                       sum_ok;

   // one LCG step; draw is the top 23 bits minus 2^22 (top bit flipped)
   assign gen_next   = gen_ff * LCG_MUL + LCG_ADD;
   assign w          = signed'({~gen_ff[31], gen_ff[30:9]});
   assign brown_next = (WALK_W+1)'(walk_ff) + (WALK_W+1)'(w);
   assign pink_next  = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(w) - (SUM_W+1)'(prev_ff);
   assign tail_sum   = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(w);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // octave index: trailing zeros of the counter mod OCTAVES, zero counter counts 32
   always_comb begin
      lsb    = count_ff & (~count_ff + 32'd1);
      k_calc = (count_ff == 32'd0) ? KW'(32 % OCTAVES) : '0;
      for (int i = 0; i < 32; i++) begin
         if (lsb[i]) begin
            k_calc = k_calc | KW'(i % OCTAVES);
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   // sequencer: next state and datapath enables
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      gain_in      = gain_ff;
      gen_in       = gen_ff;
      walk_in      = walk_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      store_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = action_type'(req_tuser);
               gain_in   = signed'(req_tdata);
               case (action_type'(req_tuser))
                  ACT_NONE: begin
                     res_in   = '0;
                     state_in = S_POST;
                  end
                  ACT_PINK: begin
                     k_in     = k_calc;
                     state_in = S_READ;
                  end
                  default: state_in = S_DRAW;
               endcase
            end
         end
         S_READ: state_in = S_DRAW;
         S_DRAW: begin
            gen_in   = gen_next;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (action_ff)
               ACT_WHITE: begin
                  prod_in  = PROD_W'(w) * PROD_W'(gain_ff);
                  state_in = S_SCALE;
               end
               ACT_BROWN: begin
                  if (brown_next >= -BROWN_LIMIT && brown_next <= BROWN_LIMIT) begin
                     walk_in  = WALK_W'(brown_next);
                     res_in   = SAMPLE_W'(brown_next);
                     state_in = S_POST;
                  end else begin
                     state_in = S_DRAW;
                  end
               end
               ACT_PINK: begin
                  // rejected draws still overwrite the entry
                  store_we = 1'b1;
                  if (pink_next >= -PINK_LIMIT && pink_next <= PINK_LIMIT) begin
                     sum_in   = SUM_W'(pink_next);
                     count_in = count_ff + 32'd1;
                     state_in = S_TAIL;
                  end else begin
                     state_in = S_DRAW;
                  end
               end
               default: state_in = S_POST;
            endcase
         end
         S_SCALE: begin
            // arithmetic shift is floor(p / 16)
            res_in   = SAMPLE_W'(prod_ff >>> 4);
            state_in = S_POST;
         end
         S_TAIL: begin
            gen_in   = gen_next;
            state_in = S_LAST;
         end
         S_LAST: begin
            res_in   = SAMPLE_W'(tail_sum) <<< 1;
            state_in = S_POST;
         end
         S_POST: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // seed write reloads the generator
      if (csr_we) begin
         gen_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= 32'd1;
         walk_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= 32'd1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         walk_ff      <= walk_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            valid_ff[k_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      gain_ff     <= gain_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // octave store port: one write, one registered read
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[k_ff] <= STORE_W'(w);
      end
      if (state_ff == S_READ) begin
         prev_ff <= valid_ff[k_ff] ? store[k_ff] : '0;
      end
   end

   // walk and sum never leave their bands
   assign walk_ok = (WALK_W+1)'(walk_ff) >= -BROWN_LIMIT
                    && (WALK_W+1)'(walk_ff) <= BROWN_LIMIT;
   assign sum_ok  = (SUM_W+1)'(sum_ff) >= -PINK_LIMIT && (SUM_W+1)'(sum_ff) <= PINK_LIMIT;
   `WBPN_ASSERT_NOW(a_walk_band, clock, reset, 1'b1, walk_ok)
   `WBPN_ASSERT_NOW(a_sum_band, clock, reset, 1'b1, sum_ok)
   // a store read is always followed by a draw
   `WBPN_ASSERT_NEXT(a_read_draw, clock, reset, state_ff == S_READ, state_ff == S_DRAW)

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the white/brown/pink noise generator core.
`timescale 1ns / 100ps

module testbench;
   import wbpn_pkg::*;

   localparam int OCTAVES    = OCTAVES_DEF;
   localparam int WALK_BAND  = 1 << 25;     // brown walk stays within +-8.0
   localparam int PINK_BAND  = 1 << 24;     // pink sum stays within +-4.0
   localparam int SETTLE     = 16;          // quiet cycles before a seed write / the verdict
   localparam int MAX_GAP    = 8;
   localparam int RAND_ITEMS = 300;         // per random phase, six phases
   localparam int CYCLE_LIMIT = 400_000;    // watchdog bound on the length of a full run

   typedef struct packed {
      action_type  action;
      logic [15:0] gain;
   } noise_req_type;

   // DUT signals; the inputs are driven to known values from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] white_gain
   logic [1:0]  req_tuser = '0;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [34:0] sample, [39:35] zero
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   // stimulus and scoreboard
   noise_req_type pending_reqs[$];
   logic [34:0] expected_samples[$];
   int          reqs_unsent = 0;   // queued but not yet accepted by the DUT
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          pace_on = 1'b1;    // random gaps/stalls on both sides when set
   bit          req_fired = 1'b0;  // request transaction at the last rising edge
   bit          rsp_fired = 1'b0;  // response transaction at the last rising edge
   int          req_gap = 0;
   int          rsp_wait = 0;

   // predicted generator state
   logic [31:0] lcg_state = 32'd1;
   int          walk_level = 0;
   int          pink_total = 0;
   logic [31:0] octave_counter = 32'd1;
   int          octave_bank[OCTAVES];

   white_brown_pink_noise_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // One LCG step; the draw is the top 23 bits recentered to [-2^22, 2^22).
   // Subtracting 2^22 from the unsigned field is the same as flipping its MSB.
   function automatic int lcg_draw();
      lcg_state = lcg_state * LCG_MUL + LCG_ADD;
      return int'(signed'({~lcg_state[31], lcg_state[30:9]}));
   endfunction

   function automatic int trailing_zero_count(logic [31:0] v);
      int n;
      n = 0;
      while (n < 32 && !v[n])
         n++;
      return n;
   endfunction

   // Expected 35-bit sample for one accepted request; advances the predicted state.
   function automatic logic [34:0] predict_sample(action_type act, logic [15:0] gain);
      longint level;
      int     candidate;
      int     k;
      int     prev;
      int     fresh;
      level = 0;
      case (act)
         ACT_WHITE: begin
            // floor(w * gain / 16): an arithmetic shift rounds toward -inf
            level = (longint'(lcg_draw()) * longint'($signed(gain))) >>> 4;
         end
         ACT_BROWN: begin
            // redraw until the step keeps the walk in band
            do
               candidate = walk_level + lcg_draw();
            while (candidate < -WALK_BAND || candidate > WALK_BAND);
            walk_level = candidate;
            level = walk_level;
         end
         ACT_PINK: begin
            // octave picked by trailing zeros; rejected draws still land in the bank
            k = trailing_zero_count(octave_counter) % OCTAVES;
            prev = octave_bank[k];
            do begin
               fresh = lcg_draw();
               octave_bank[k] = fresh;
               candidate = pink_total + fresh - prev;
            end while (candidate < -PINK_BAND || candidate > PINK_BAND);
            pink_total = candidate;
            octave_counter = octave_counter + 32'd1;
            level = 2 * (longint'(lcg_draw()) + longint'(pink_total));
         end
         default: level = 0;   // unused action: zero, state untouched
      endcase
      return level[34:0];
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver: falling edge, fed from pending_reqs
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      noise_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (req_fired)
            req_gap = pace_on ? $urandom_range(0, MAX_GAP) : 0;
         if (req_gap > 0 || pending_reqs.size() == 0) begin
            if (req_gap > 0)
               req_gap--;
            req_tvalid <= 1'b0;
         end else begin
            // valid stays high back to back when no gap was drawn
            item = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.gain;
            req_tuser  <= item.action;
         end
      end
   end

   // Response side: a random stall drawn after every response transaction
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fired)
            rsp_wait = pace_on ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: rising edge; predicts on each request transaction, checks each response
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [34:0] want;
      req_fired = 1'b0;
      rsp_fired = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            reqs_unsent--;
            expected_samples.push_back(predict_sample(action_type'(req_tuser), req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_fired = 1'b1;
            if (expected_samples.size() == 0) begin
               $error("sample: unexpected response transaction, got %0d",
                      $signed(rsp_tdata[34:0]));
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[34:0] !== want) begin
                  $error("sample: expected %0d, got %0d", $signed(want),
                         $signed(rsp_tdata[34:0]));
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[white_brown_pink_noise_generator_core] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   task automatic queue_item(action_type act, logic [15:0] gain);
      noise_req_type item;
      item.action = act;
      item.gain   = gain;
      reqs_unsent++;
      pending_reqs.push_back(item);
   endtask

   // Mostly the three colors, about one in twenty the unused action.
   task automatic queue_random(int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            queue_item(ACT_NONE, 16'($urandom()));
         else
            queue_item(action_type'(pick % 3), 16'($urandom()));
      end
   endtask

   // Every item yields a response, so empty queues mean the core is back in idle;
   // the settle time covers the trailing cycles anyway.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (reqs_unsent != 0 || expected_samples.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Seed write reloads the generator only; walk, sum, counter and bank carry over.
   task automatic load_seed(logic [31:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      lcg_state = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [31:0] phase_seed[6];
      for (int i = 0; i < OCTAVES; i++)
         octave_bank[i] = 0;
      phase_seed[0] = 32'h0000_0000;   // zero seed still runs: odd increment
      phase_seed[1] = 32'hFFFF_FFFF;
      phase_seed[2] = 32'h8000_0000;
      phase_seed[3] = $urandom();
      phase_seed[4] = $urandom();
      phase_seed[5] = 32'h0000_0001;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: gain extremes for white, unused action, brown/pink runs, reset seed
      queue_item(ACT_WHITE, 16'h7FFF);
      queue_item(ACT_WHITE, 16'h8000);
      queue_item(ACT_WHITE, 16'h0000);
      queue_item(ACT_WHITE, 16'hFFFF);
      queue_item(ACT_WHITE, 16'h0100);
      queue_item(ACT_WHITE, 16'h0001);
      queue_item(ACT_NONE,  16'h8000);
      queue_item(ACT_NONE,  16'h7FFF);
      for (int i = 0; i < 5; i++)
         queue_item(ACT_BROWN, i[0] ? 16'hFFFF : 16'h0000);
      for (int i = 0; i < 8; i++)
         queue_item(ACT_PINK, i[0] ? 16'h5555 : 16'hAAAA);
      queue_item(ACT_NONE,  16'h0000);
      queue_item(ACT_WHITE, 16'h8000);
      queue_item(ACT_BROWN, 16'h7FFF);
      wait_drained();

      // random phases, each under its own seed; one phase runs with no gaps or stalls
      for (int p = 0; p < 6; p++) begin
         load_seed(phase_seed[p]);
         pace_on = (p != 2);
         queue_random(RAND_ITEMS);
         wait_drained();
      end

      // closing back-to-back items under a fresh seed
      load_seed($urandom());
      pace_on = 1'b0;
      queue_item(ACT_BROWN, 16'h0000);
      queue_item(ACT_WHITE, 16'h7FFF);
      wait_drained();

      if (fail_count == 0)
         $display("[white_brown_pink_noise_generator_core] OK");
      else
         $display("[white_brown_pink_noise_generator_core] ERROR");
      $finish;
   end

endmodule
